FILE: src/bda_pkg.sv
// shared types and constants of the button debounce and autorepeat block
package bda_pkg;

   localparam int unsigned CfgWidth   = 16;
   localparam int unsigned StampWidth = 32;
   localparam int unsigned EventWidth = 3;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned DivCntWidth = $clog2(StampWidth);

   // register indexes of the configuration port
   localparam logic [CsrIdxWidth-1:0] CSR_FORCE_TIME      = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE_TIME   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_AUTOPRESS_DELAY = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_REPEAT_PERIOD   = 2'd3;

   localparam logic [CfgWidth-1:0] FORCE_TIME_RESET      = 16'd150;
   localparam logic [CfgWidth-1:0] DEBOUNCE_TIME_RESET   = 16'd50;
   localparam logic [CfgWidth-1:0] AUTOPRESS_DELAY_RESET = 16'd500;
   localparam logic [CfgWidth-1:0] REPEAT_PERIOD_RESET   = 16'd200;

   // event codes
   localparam logic [EventWidth-1:0] EV_RELEASED     = 3'd0;
   localparam logic [EventWidth-1:0] EV_PRESS_EDGE   = 3'd1;
   localparam logic [EventWidth-1:0] EV_HELD         = 3'd2;
   localparam logic [EventWidth-1:0] EV_AUTOREPEAT   = 3'd3;
   localparam logic [EventWidth-1:0] EV_RELEASE_EDGE = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic update;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } stat_type;

endpackage

FILE: src/bda_if.sv
// valid/ready channel interfaces for button samples and events
interface bda_req_if;
   import bda_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [StampWidth-1:0] now_ms;
   logic                  raw_level;

   modport source (output valid, output now_ms, output raw_level, input ready);
   modport sink   (input valid, input now_ms, input raw_level, output ready);
endinterface

interface bda_rsp_if;
   import bda_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [EventWidth-1:0] event_res;

   modport source (output valid, output event_res, input ready);
   modport sink   (input valid, input event_res, output ready);
endinterface

FILE: src/bda_ctrl.sv
// controller state machine: sequences update, modulo steps and event output
module bda_ctrl
   import bda_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = stat.need_div ? ST_DIVIDE : ST_EMIT;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/bda_dp.sv
// datapath: configuration, debounce state, event decode and serial modulo
module bda_dp
   import bda_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]    csr_wdata,
   input  logic [StampWidth-1:0]  now_ms,
   input  logic                   raw_level,
   input  cmd_type                cmd,
   output stat_type               stat,
   output logic [EventWidth-1:0]  event_res
);

   logic [CfgWidth-1:0]    force_time_ff, debounce_time_ff;
   logic [CfgWidth-1:0]    autopress_delay_ff, repeat_period_ff;
   logic                   latched_raw_ff, debounced_ff;
   logic [StampWidth-1:0]  change_stamp_ff, press_stamp_ff;
   logic [StampWidth-1:0]  now_ff;
   logic                   level_ff;
   logic [EventWidth-1:0]  base_event_ff, base_event_in;
   logic                   need_div_ff, need_div_in;
   logic [EventWidth-1:0]  event_ff;
   logic [StampWidth-1:0]  quo_ff;
   logic [CfgWidth-1:0]    rem_ff, rem_in;
   logic [DivCntWidth-1:0] div_cnt_ff;

   logic [StampWidth-1:0]  change_age, held_age;
   logic                   force_sync, raw_change, age_zero;
   logic                   latched_in, debounced_in;
   logic [StampWidth-1:0]  change_stamp_in, press_stamp_in;
   logic [CfgWidth:0]      rem_shift;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         force_time_ff      <= FORCE_TIME_RESET;
         debounce_time_ff   <= DEBOUNCE_TIME_RESET;
         autopress_delay_ff <= AUTOPRESS_DELAY_RESET;
         repeat_period_ff   <= REPEAT_PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FORCE_TIME:      force_time_ff      <= csr_wdata;
            CSR_DEBOUNCE_TIME:   debounce_time_ff   <= csr_wdata;
            CSR_AUTOPRESS_DELAY: autopress_delay_ff <= csr_wdata;
            CSR_REPEAT_PERIOD:   repeat_period_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // debounce and edge decode, done in the update cycle
   always_comb begin
      change_age = now_ff - change_stamp_ff;
      held_age   = now_ff - press_stamp_ff;
      force_sync = change_age >= {{(StampWidth-CfgWidth){1'b0}}, force_time_ff};
      raw_change = level_ff != latched_raw_ff;

      latched_in      = latched_raw_ff;
      debounced_in    = debounced_ff;
      change_stamp_in = change_stamp_ff;
      if (force_sync) begin
         latched_in      = level_ff;
         debounced_in    = level_ff;
         change_stamp_in = now_ff;
      end else if (raw_change) begin
         latched_in      = level_ff;
         change_stamp_in = now_ff;
      end

      // a fresh change stamp means the age is now zero
      age_zero = force_sync || raw_change;
      if (age_zero) begin
         if (debounce_time_ff == '0) begin
            debounced_in = latched_in;
         end
      end else if (change_age >= {{(StampWidth-CfgWidth){1'b0}}, debounce_time_ff}) begin
         debounced_in = latched_in;
      end

      press_stamp_in = press_stamp_ff;
      need_div_in    = 1'b0;
      if (debounced_in && !debounced_ff) begin
         press_stamp_in = now_ff;
         base_event_in  = EV_PRESS_EDGE;
      end else if (!debounced_in && debounced_ff) begin
         press_stamp_in = '0;
         base_event_in  = EV_RELEASE_EDGE;
      end else if (debounced_in) begin
         base_event_in = EV_HELD;
         need_div_in   = (held_age > {{(StampWidth-CfgWidth){1'b0}}, autopress_delay_ff})
                         && (repeat_period_ff != '0);
      end else begin
         base_event_in = EV_RELEASED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_raw_ff  <= 1'b0;
         debounced_ff    <= 1'b0;
         change_stamp_ff <= '0;
         press_stamp_ff  <= '0;
      end else if (cmd.update) begin
         latched_raw_ff  <= latched_in;
         debounced_ff    <= debounced_in;
         change_stamp_ff <= change_stamp_in;
         press_stamp_ff  <= press_stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         now_ff   <= now_ms;
         level_ff <= raw_level;
      end
      if (cmd.update) begin
         base_event_ff <= base_event_in;
         need_div_ff   <= need_div_in;
      end
   end

   // restoring remainder, one quotient bit per cycle
   always_comb begin
      rem_shift = {rem_ff, quo_ff[StampWidth-1]};
      if (rem_shift >= {1'b0, repeat_period_ff}) begin
         rem_in = CfgWidth'(rem_shift - {1'b0, repeat_period_ff});
      end else begin
         rem_in = rem_shift[CfgWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.update) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         quo_ff <= now_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[StampWidth-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (need_div_ff && rem_ff == '0) begin
            event_ff <= EV_AUTOREPEAT;
         end else begin
            event_ff <= base_event_ff;
         end
      end
   end

   assign stat.need_div = need_div_in;
   assign stat.div_done = div_cnt_ff == DivCntWidth'(StampWidth - 1);
   assign event_res     = event_ff;

endmodule

FILE: src/button_debounce_autorepeat_core.sv
// Button debounce with autorepeat. Each transfer on the request channel is one raw
// button sample with its wrapping millisecond timestamp and gives exactly one event on
// the response channel (released, press edge, held, autorepeat, release edge). One
// sample is worked on at a time: a sample passes through the update and emit states, and
// also through the divide state when the button has been held past the autopress delay
// with a nonzero repeat period, since the check of the timestamp against the repeat
// period runs through a remainder unit that retires one timestamp bit per cycle. A
// finished event waits in an output register, so a new sample is taken while the
// previous event is still unclaimed. Configuration is written through the csr_ port;
// the user must write it only while no sample is in progress; the block does not enforce it.
module button_debounce_autorepeat_core
   import bda_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   bda_req_if.sink                req_ch,
   bda_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]    csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   bda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   bda_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .now_ms    (req_ch.now_ms),
      .raw_level (req_ch.raw_level),
      .cmd       (cmd),
      .stat      (stat),
      .event_res (rsp_ch.event_res)
   );

endmodule
